// ===== hw/rtl/ctr_pkg.sv =====
// package for the chunked transfer reassembler
// holds sizes, transaction payload types and the buffer address helper
// no dependencies
`default_nettype none

package ctr_pkg;

  localparam int BUFFER_BYTES   = 64;
  localparam int SLOT_COUNT     = 4;
  localparam int WORDS          = (BUFFER_BYTES + 3) / 4;
  localparam int RAM_DEPTH      = SLOT_COUNT * WORDS;
  localparam int SLOT_IW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORD_IW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ADDR_W         = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int LEN_W          = 7;
  localparam int OFS_W          = 6;

  localparam logic [7:0] BCAST_ID = 8'hFF;
  localparam logic [3:0] WR_MIN_LEN = 4'd8;
  localparam logic [3:0] CM_MIN_LEN = 4'd6;

  localparam logic [1:0] CFG_NODE_ID   = 2'd0;
  localparam logic [1:0] CFG_WRITE_ID  = 2'd1;
  localparam logic [1:0] CFG_COMMIT_ID = 2'd2;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic        from_self;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_namespace;
    logic [7:0]       out_key;
    logic [LEN_W-1:0] total_length;
    logic [7:0]       commit_flags;
    logic [OFS_W-1:0] byte_offset;
    logic [7:0]       data_out;
    logic             has_data;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic               write_go;
    logic               store;
    logic [WORD_IW-1:0] word;
    logic               free_go;
    logic [SLOT_IW-1:0] free_slot;
    logic [SLOT_IW-1:0] mark_slot;
    logic [WORD_IW-1:0] mark_word;
  } tbl_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_IW-1:0] hit_slot;
    logic [SLOT_IW-1:0] wr_slot;
    logic               mark;
  } tbl_rsp_t;

  function automatic logic [ADDR_W-1:0] buf_addr(input logic [SLOT_IW-1:0] slot,
                                                 input logic [WORD_IW-1:0] word);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(slot) * ADDR_W'(WORDS);
    return base + ADDR_W'(word);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctr_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module ctr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctr_slot_tbl.sv =====
// slot table: open flags, namespace/key tags and per-word written marks
// depends on ctr_pkg
`default_nettype none

module ctr_slot_tbl
  import ctr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] ns,
  input  wire logic [7:0] key,
  input  wire tbl_cmd_t   cmd,
  output tbl_rsp_t        rsp
);

  logic               active_r [SLOT_COUNT];
  logic [7:0]         ns_r     [SLOT_COUNT];
  logic [7:0]         key_r    [SLOT_COUNT];
  logic [WORDS-1:0]   marks_r  [SLOT_COUNT];
  logic               hit;
  logic [SLOT_IW-1:0] hit_slot;
  logic [SLOT_IW-1:0] alloc_slot;
  logic [SLOT_IW-1:0] wr_slot;
  logic [WORDS-1:0]   word_bit;

  // lowest matching slot and lowest free slot, slot 0 when all are taken
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    alloc_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (active_r[i] && ns_r[i] == ns && key_r[i] == key) begin
        hit      = 1'b1;
        hit_slot = SLOT_IW'(i);
      end
      if (!active_r[i]) begin
        alloc_slot = SLOT_IW'(i);
      end
    end
  end

  assign wr_slot  = hit ? hit_slot : alloc_slot;
  assign word_bit = WORDS'(1) << cmd.word;

  assign rsp.hit      = hit;
  assign rsp.hit_slot = hit_slot;
  assign rsp.wr_slot  = wr_slot;
  assign rsp.mark     = marks_r[cmd.mark_slot][cmd.mark_word];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        active_r[i] <= 1'b0;
        marks_r[i]  <= '0;
      end
    end else begin
      if (cmd.write_go) begin
        active_r[wr_slot] <= 1'b1;
        if (!hit) begin
          marks_r[wr_slot] <= cmd.store ? word_bit : '0;
        end else if (cmd.store) begin
          marks_r[wr_slot] <= marks_r[wr_slot] | word_bit;
        end
      end
      if (cmd.free_go) begin
        active_r[cmd.free_slot] <= 1'b0;
      end
    end
  end

  // tags of a newly allocated slot
  always_ff @(posedge clk) begin
    if (cmd.write_go && !hit) begin
      ns_r[wr_slot]  <= ns;
      key_r[wr_slot] <= key;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_transfer_reassembler_top.sv =====
// Chunked transfer reassembler. A frame that is ignored or that writes a
// chunk does not stall the input; for a write the slot table is searched
// and the chunk word is written to the buffer ram in the cycle the frame is
// accepted. A commit frame starts with the first buffer ram read, then
// gives one result per cycle as long as out_stall stays low; a zero-length
// commit gives a single result. The single buffer ram read port paces the
// stream. While a commit streams, in_stall is high; the last result sits in
// an output register, so the next frame is taken while it waits. No clearing
// pass is needed after reset: per-word written marks make unwritten bytes read zero.
// depends on ctr_pkg, ctr_ram, ctr_slot_tbl
`default_nettype none

module chunked_transfer_reassembler_top
  import ctr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_wdata
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic               state_r, state_nxt;
  logic [7:0]         node_id_r;
  logic [28:0]        write_id_r;
  logic [28:0]        commit_id_r;

  logic [7:0]         ns_r, key_r, flags_r;
  logic [LEN_W-1:0]   len_r;
  logic [SLOT_IW-1:0] slot_r;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic               out_valid_r;
  out_item_t          out_q_r;

  logic               accept;
  logic               frame_ok;
  logic               is_write;
  logic               is_commit;
  logic               go_write;
  logic               go_commit;
  logic [15:0]        len16;
  logic               len_ok;
  logic               store;
  logic               can_load;
  logic               load;
  logic               is_last;
  logic [7:0]         sel_byte;

  tbl_cmd_t           cmd;
  tbl_rsp_t           rsp;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [31:0]        ram_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r   <= '0;
      write_id_r  <= '0;
      commit_id_r <= 29'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:   node_id_r   <= cfg_wdata[7:0];
        CFG_WRITE_ID:  write_id_r  <= cfg_wdata;
        CFG_COMMIT_ID: commit_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame decode
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign frame_ok  = !in_data.from_self &&
                     (in_data.byte_0 == node_id_r || in_data.byte_0 == BCAST_ID);
  assign is_write  = (in_data.frame_id == write_id_r) && (in_data.frame_length >= WR_MIN_LEN);
  assign is_commit = !is_write && (in_data.frame_id == commit_id_r) &&
                     (in_data.frame_length >= CM_MIN_LEN);
  assign len16     = {in_data.byte_4, in_data.byte_3};
  assign len_ok    = len16 <= 16'(BUFFER_BYTES);
  assign store     = in_data.byte_3 < 8'(WORDS);
  assign go_write  = accept && frame_ok && is_write;
  assign go_commit = accept && frame_ok && is_commit && rsp.hit && len_ok;

  // stream control
  assign can_load = !out_valid_r || !out_stall;
  assign load     = (state_r == ST_STREAM) && can_load;
  assign is_last  = (len_r == '0) || (k_r + LEN_W'(1) == len_r);
  assign k_nxt    = k_r + LEN_W'(1);
  assign sel_byte = ram_rdata[{k_r[1:0], 3'b000} +: 8];

  always_comb begin
    cmd           = '0;
    cmd.write_go  = go_write;
    cmd.store     = store;
    cmd.word      = in_data.byte_3[WORD_IW-1:0];
    cmd.free_go   = load && is_last;
    cmd.free_slot = slot_r;
    cmd.mark_slot = slot_r;
    cmd.mark_word = k_r[WORD_IW+1:2];
  end

  ctr_slot_tbl u_slot_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .ns    (in_data.byte_1),
    .key   (in_data.byte_2),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  // chunk words are written whole; bytes past the buffer end are never read
  assign ram_we    = go_write && store;
  assign ram_waddr = buf_addr(rsp.wr_slot, in_data.byte_3[WORD_IW-1:0]);
  assign ram_wdata = {in_data.byte_7, in_data.byte_6, in_data.byte_5, in_data.byte_4};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = buf_addr(slot_r, k_nxt[WORD_IW+1:2]);
    if (go_commit) begin
      ram_re    = 1'b1;
      ram_raddr = buf_addr(rsp.hit_slot, '0);
    end else if (load && !is_last) begin
      ram_re = 1'b1;
    end
  end

  ctr_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (go_commit) state_nxt = ST_STREAM;
      ST_STREAM: if (load && is_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // commit context and output register
  always_ff @(posedge clk) begin
    if (go_commit) begin
      ns_r    <= in_data.byte_1;
      key_r   <= in_data.byte_2;
      flags_r <= in_data.byte_5;
      len_r   <= len16[LEN_W-1:0];
      slot_r  <= rsp.hit_slot;
      k_r     <= '0;
    end else if (load) begin
      k_r <= k_nxt;
    end
    if (load) begin
      out_q_r.out_namespace <= ns_r;
      out_q_r.out_key       <= key_r;
      out_q_r.total_length  <= len_r;
      out_q_r.commit_flags  <= flags_r;
      out_q_r.byte_offset   <= k_r[OFS_W-1:0];
      out_q_r.data_out      <= (len_r == '0 || !rsp.mark) ? 8'd0 : sel_byte;
      out_q_r.has_data      <= (len_r != '0);
      out_q_r.last          <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

endmodule

`default_nettype wire

// ===== test/chunked_transfer_reassembler_top_tb.sv =====
// testbench for chunked_transfer_reassembler_top: directed frame table, then random
// write/commit traffic checked against an in-bench slot and buffer predictor
// depends on ctr_pkg and the reassembler rtl
`timescale 1ns / 100ps

module chunked_transfer_reassembler_top_tb
  import ctr_pkg::*;
;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAG_COUNT     = 6;
  localparam int SHOW_LIMIT    = 10;

  typedef enum {ROW_PREDICT, ROW_SILENT, ROW_SINGLE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_item_t  frame;
    out_item_t result;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_NODE_ID;
  logic [28:0] cfg_wdata = '0;

  chunked_transfer_reassembler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]       own_node;
  logic [28:0]      write_id;
  logic [28:0]      commit_id;
  logic             slot_open  [SLOT_COUNT];
  logic [7:0]       slot_space [SLOT_COUNT];
  logic [7:0]       slot_tag   [SLOT_COUNT];
  logic [WORDS-1:0] word_marks [SLOT_COUNT];
  logic [31:0]      slot_words [SLOT_COUNT][WORDS];
  out_item_t        pending_results[$];

  logic [15:0] transfer_tags [TAG_COUNT];
  int sender_idle_pct = 12;
  int receiver_idle_pct = 57;

  int frames_sent = 0;
  int frames_taken = 0;
  int commits = 0;
  int takeovers = 0;
  int settings = 1;
  int results_checked = 0;
  int mismatches = 0;
  int unexpected = 0;
  int quiet_cycles = 0;

  function automatic in_item_t frame_of(logic [28:0] id, logic [3:0] dlc, logic self,
                                        logic [63:0] payload);
    return {id, dlc, self, payload};
  endfunction

  function automatic string show_result(out_item_t r);
    return $sformatf("ns=%h key=%h len=%0d flags=%h ofs=%0d data=%h has=%b last=%b",
                     r.out_namespace, r.out_key, r.total_length, r.commit_flags,
                     r.byte_offset, r.data_out, r.has_data, r.last);
  endfunction

  function automatic int open_slot_of(logic [7:0] space, logic [7:0] tag);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_open[i] && slot_space[i] == space && slot_tag[i] == tag) return i;
    return -1;
  endfunction

  // updates slot state for one frame, queues its results if queue_results is set; returns 1 unless ignored
  function automatic bit apply_frame(in_item_t f, bit queue_results);
    int s;
    int offset;
    int len;
    int room;
    int n;
    int w;
    bit is_write;
    bit is_commit;
    logic [31:0] word;
    logic [31:0] chunk;
    out_item_t r;
    if (f.from_self) return 1'b0;
    is_write  = (f.frame_id == write_id) && (f.frame_length >= WR_MIN_LEN);
    is_commit = !is_write && (f.frame_id == commit_id) && (f.frame_length >= CM_MIN_LEN);
    if (!is_write && !is_commit) return 1'b0;
    if (f.byte_0 != own_node && f.byte_0 != BCAST_ID) return 1'b0;
    frames_taken++;
    s = open_slot_of(f.byte_1, f.byte_2);
    if (is_write) begin
      if (s < 0) begin
        s = 0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (!slot_open[i]) s = i;
        if (slot_open[s]) takeovers++;
        slot_space[s] = f.byte_1;
        slot_tag[s]   = f.byte_2;
        word_marks[s] = '0;
        slot_open[s]  = 1'b1;
      end
      offset = 4 * int'(f.byte_3);
      if (offset < BUFFER_BYTES) begin
        w     = offset / 4;
        room  = BUFFER_BYTES - offset;
        n     = (room >= 4) ? 4 : room;
        chunk = {f.byte_7, f.byte_6, f.byte_5, f.byte_4};
        word  = word_marks[s][w] ? slot_words[s][w] : 32'h0;
        for (int k = 0; k < n; k++) word[8*k +: 8] = chunk[8*k +: 8];
        slot_words[s][w]    = word;
        word_marks[s][w]    = 1'b1;
      end
    end else begin
      len = int'({f.byte_4, f.byte_3});
      if (s < 0 || len > BUFFER_BYTES) return 1'b1;
      commits++;
      if (queue_results) begin
        if (len == 0) begin
          r = '{f.byte_1, f.byte_2, '0, f.byte_5, '0, 8'h00, 1'b0, 1'b1};
          pending_results.push_back(r);
        end
        for (int k = 0; k < len; k++) begin
          r.out_namespace = f.byte_1;
          r.out_key       = f.byte_2;
          r.total_length  = LEN_W'(len);
          r.commit_flags  = f.byte_5;
          r.byte_offset   = OFS_W'(k);
          r.data_out      = word_marks[s][k / 4] ? slot_words[s][k / 4][8 * (k % 4) +: 8]
                                                 : 8'h00;
          r.has_data      = 1'b1;
          r.last          = (k == len - 1);
          pending_results.push_back(r);
        end
      end
      slot_open[s] = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_target();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return own_node;
    if (roll < 90) return BCAST_ID;
    return 8'($urandom);
  endfunction

  // mostly well-formed chunk writes and commits on a small set of transfers, rest noise
  function automatic in_item_t random_frame();
    in_item_t f;
    int roll;
    int len;
    f.frame_id     = 29'($urandom);
    f.frame_length = 4'($urandom_range(8));
    f.from_self    = ($urandom_range(99) < 5);
    {f.byte_0, f.byte_1, f.byte_2, f.byte_3} = $urandom;
    {f.byte_4, f.byte_5, f.byte_6, f.byte_7} = $urandom;
    roll = $urandom_range(99);
    if (roll < 45) begin
      f.frame_id         = write_id;
      f.frame_length     = WR_MIN_LEN;
      f.byte_0           = random_target();
      {f.byte_1, f.byte_2} = transfer_tags[$urandom_range(TAG_COUNT - 1)];
      f.byte_3           = ($urandom_range(99) < 90) ? 8'($urandom_range(WORDS - 1))
                                                     : 8'($urandom);
    end else if (roll < 70) begin
      f.frame_id         = commit_id;
      f.frame_length     = 4'($urandom_range(8, 6));
      f.byte_0           = random_target();
      {f.byte_1, f.byte_2} = transfer_tags[$urandom_range(TAG_COUNT - 1)];
      roll = $urandom_range(99);
      if (roll < 75) len = $urandom_range(16);
      else if (roll < 92) len = $urandom_range(BUFFER_BYTES, 17);
      else len = $urandom_range(65535);
      {f.byte_4, f.byte_3} = 16'(len);
    end else begin
      roll = $urandom_range(2);
      if (roll == 0) f.frame_id = write_id;
      else if (roll == 1) f.frame_id = commit_id;
      f.from_self = 1'($urandom_range(1));
      if ($urandom_range(1)) f.byte_0 = random_target();
    end
    return f;
  endfunction

  task automatic send_frame(in_item_t f);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    frames_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [28:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      CFG_NODE_ID:   own_node  = value[7:0];
      CFG_WRITE_ID:  write_id  = value;
      CFG_COMMIT_ID: commit_id = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [7:0] node, logic [28:0] wid, logic [28:0] cid,
                           int send_pct, int recv_pct, int frames);
    int taken;
    in_item_t f;
    drain_results();
    write_register(CFG_NODE_ID, {21'd0, node});
    write_register(CFG_WRITE_ID, wid);
    write_register(CFG_COMMIT_ID, cid);
    cfg_we <= 1'b0;
    for (int i = 0; i < TAG_COUNT; i++) transfer_tags[i] = 16'($urandom);
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    settings++;
    taken = 0;
    while (taken < frames) begin
      f = random_frame();
      send_frame(f);
      void'(apply_frame(f, 1'b1));
      taken++;
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < receiver_idle_pct);

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= SHOW_LIMIT)
          $display("unexpected result: %s", show_result(out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_namespace !== want.out_namespace || out_data.out_key !== want.out_key ||
            out_data.total_length !== want.total_length ||
            out_data.commit_flags !== want.commit_flags ||
            out_data.byte_offset !== want.byte_offset || out_data.data_out !== want.data_out ||
            out_data.has_data !== want.has_data || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches + unexpected <= SHOW_LIMIT) begin
            $display("mismatch at result %0d", results_checked);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(out_data));
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    frame_row_t rows[$];
    int failures;
    own_node  = 8'h00;
    write_id  = 29'd0;
    commit_id = 29'd1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_open[i]  = 1'b0;
      slot_space[i] = 8'h00;
      slot_tag[i]   = 8'h00;
      word_marks[i] = '0;
      for (int j = 0; j < WORDS; j++) slot_words[i][j] = 32'h0;
    end

    // reset config: node 0, write id 0, commit id 1
    rows.push_back('{ROW_SILENT, frame_of(29'd1, 4'd8, 1'b0, 64'h00_11_22_04_00_00_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b1, 64'hFF_11_22_00_AA_BB_CC_DD), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_11_22_00_AA_BB_CC_DD), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'h00_11_22_0F_01_02_03_04), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'h00_11_22_10_EE_EE_EE_EE), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_11_22_FF_FF_FF_FF_FF), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd7, 1'b0, 64'h00_11_22_01_55_55_55_55), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'h05_11_22_02_66_66_66_66), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd1, 4'd8, 1'b1, 64'h00_11_22_40_00_00_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd1, 4'd8, 1'b0, 64'h00_11_22_41_00_00_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd1, 4'd8, 1'b0, 64'h00_11_22_00_01_00_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd1, 4'd5, 1'b0, 64'h00_11_22_40_00_00_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'h1FFFFFFF, 4'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF), '0});
    rows.push_back('{ROW_PREDICT, frame_of(29'd1, 4'd8, 1'b0, 64'hFF_11_22_40_00_FF_00_00), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'h00_00_00_00_12_34_56_78), '0});
    rows.push_back('{ROW_SINGLE, frame_of(29'd1, 4'd6, 1'b0, 64'h00_00_00_00_00_A5_00_00),
                     '{8'h00, 8'h00, 7'd0, 8'hA5, 6'd0, 8'h00, 1'b0, 1'b1}});
    // fill every slot, then one more transfer takes over slot 0
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_01_80_01_C0_C1_C2_C3), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_02_80_01_C4_C5_C6_C7), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_03_80_01_C8_C9_CA_CB), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_04_80_01_CC_CD_CE_CF), '0});
    rows.push_back('{ROW_SILENT, frame_of(29'd0, 4'd8, 1'b0, 64'hFF_05_80_02_D0_D1_D2_D3), '0});
    rows.push_back('{ROW_PREDICT, frame_of(29'd1, 4'd8, 1'b0, 64'h00_01_80_08_00_3C_00_00), '0});
    rows.push_back('{ROW_PREDICT, frame_of(29'd1, 4'd7, 1'b0, 64'hFF_05_80_0C_00_00_00_00), '0});
    rows.push_back('{ROW_PREDICT, frame_of(29'd1, 4'd6, 1'b0, 64'h00_02_80_08_00_81_00_00), '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_frame(rows[i].frame);
      if (rows[i].kind == ROW_PREDICT) begin
        void'(apply_frame(rows[i].frame, 1'b1));
      end else begin
        void'(apply_frame(rows[i].frame, 1'b0));
        if (rows[i].kind == ROW_SINGLE) pending_results.push_back(rows[i].result);
      end
    end

    run_phase(8'h3C, 29'h0123_4567, 29'h0ABC_DEF0, 12, 57, 97);
    run_phase(8'hFF, 29'h1FFF_FFFF, 29'h000_0000, 57, 12, 97);
    run_phase(8'h00, 29'h000_0155, 29'h000_0155, 0, 0, 97);
    run_phase(8'hA5, 29'h000_0000, 29'h1FFF_FFFE, 0, 0, 97);

    drain_results();
    repeat (2 * BUFFER_BYTES) @(posedge clk);
    failures = mismatches + unexpected + pending_results.size();
    $display("covered %0d frames (%0d acted on) under %0d register settings",
             frames_sent, frames_taken, settings);
    $display("%0d results checked from %0d commits, %0d slot takeovers",
             results_checked, commits, takeovers);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing results",
               mismatches, unexpected, pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
